// File: rtl/core/hbsf_pkg.sv
// ----------------------------------------------------------------------------
// hbsf_pkg
// Shared types, constants and the FCS byte update for the HDLC framer.
// ----------------------------------------------------------------------------
package hbsf_pkg;

	// Line word width; the output request is sized from it
	localparam int WORD_BITS = 8;

	// Default for the top-level parameter
	localparam int DEF_START_FLAGS = 1;

	// Chunk queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// One byte grows to at most ten line bits after stuffing
	localparam int MAX_CHUNK_BITS = 10;
	localparam int CHUNK_N_W      = 4;

	localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
	localparam logic [2:0]  STUFF_RUN  = 3'd5;
	localparam logic [15:0] FCS_PRESET = 16'hFFFF;
	localparam logic [15:0] FCS_POLY   = 16'h8408;

	localparam int          TOTAL_W   = 14;
	localparam logic [13:0] TOTAL_MAX = 14'h3FFF;

	// Input request: one frame byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       flush_tail;
	} byte_item_t;

	// Output request: one packed line word
	typedef struct packed {
		logic [WORD_BITS-1:0] out_word;
		logic [3:0]           valid_bits;
		logic                 frame_end;
		logic [TOTAL_W-1:0]   frame_bit_count;
		logic                 last_of_run;
	} word_item_t;

	// Work unit handed from the front to the back
	typedef enum logic [1:0] {
		CK_FLAG,
		CK_DATA,
		CK_TAIL
	} chunk_kind_t;

	typedef struct packed {
		chunk_kind_t kind;
		logic [7:0]  data;
		logic        first;        // first chunk of an input byte
		logic        frame_start;  // first chunk of a frame
		logic        item_end;     // last chunk of an input byte
		logic        frame_last;   // chunk belongs to the closing byte
	} chunk_t;

	// Front sequencer states
	typedef enum logic [2:0] {
		FR_IDLE,
		FR_FLAG,
		FR_DATA,
		FR_FCS_LO,
		FR_FCS_HI,
		FR_CLOSE,
		FR_TAIL
	} fr_state_t;

	// Line bits of one chunk, right aligned, earliest bit highest
	typedef struct packed {
		logic [MAX_CHUNK_BITS-1:0] bits;
		logic [CHUNK_N_W-1:0]      n;
		logic [2:0]                ones;
	} line_bits_t;

	// Advance the reflected CRC-16 by one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] byte_in);
		logic [15:0] c;
		c = crc_in ^ {8'h00, byte_in};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ FCS_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/hbsf_front.sv
// ----------------------------------------------------------------------------
// hbsf_front
// Accepts frame bytes, runs the FCS and splits each byte into chunks.
// ----------------------------------------------------------------------------
module hbsf_front
	import hbsf_pkg::*;
#(
	parameter int START_FLAGS = DEF_START_FLAGS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  byte_item_t byte_item,
	output logic       chunk_valid,
	input  logic       chunk_ready,
	output chunk_t     chunk
);

	localparam int FLAG_CNT_W = (START_FLAGS > 1) ? $clog2(START_FLAGS) : 1;

	fr_state_t               state_q, state_d;
	logic                    in_frame_q;
	logic [15:0]             fcs_q;
	logic [15:0]             fcs_out_q;
	logic [7:0]              data_q;
	logic                    last_q;
	logic                    flush_q;
	logic                    start_q;
	logic [FLAG_CNT_W-1:0]   flag_cnt_q;

	logic                    accept;
	logic                    push;
	logic                    frame_start_in;
	logic [15:0]             crc_next;
	logic                    last_flag;

	assign frame_start_in = !in_frame_q;
	assign crc_next       = crc16_byte(frame_start_in ? FCS_PRESET : fcs_q,
		byte_item.data_byte);
	assign last_flag      = (flag_cnt_q == FLAG_CNT_W'(START_FLAGS - 1));

	// Build the current chunk, the handshake and the next state
	always_comb begin
		chunk.kind        = CK_FLAG;
		chunk.data        = FLAG_BYTE;
		chunk.first       = 1'b0;
		chunk.frame_start = 1'b0;
		chunk.item_end    = 1'b0;
		chunk.frame_last  = last_q;
		chunk_valid       = (state_q != FR_IDLE);
		case (state_q)
			FR_FLAG: begin
				chunk.first       = start_q && (flag_cnt_q == '0);
				chunk.frame_start = start_q && (flag_cnt_q == '0);
			end
			FR_DATA: begin
				chunk.kind     = CK_DATA;
				chunk.data     = data_q;
				chunk.first    = !start_q;
				chunk.item_end = !last_q;
			end
			FR_FCS_LO: begin
				chunk.kind = CK_DATA;
				chunk.data = fcs_out_q[7:0];
			end
			FR_FCS_HI: begin
				chunk.kind = CK_DATA;
				chunk.data = fcs_out_q[15:8];
			end
			FR_CLOSE: begin
				chunk.item_end = !flush_q;
			end
			FR_TAIL: begin
				chunk.kind     = CK_TAIL;
				chunk.item_end = 1'b1;
			end
			default: begin
				chunk_valid = 1'b0;
			end
		endcase

		push       = chunk_valid && chunk_ready;
		byte_ready = (state_q == FR_IDLE) || (push && chunk.item_end);
		accept     = byte_valid && byte_ready;

		state_d = state_q;
		if (push) begin
			case (state_q)
				FR_FLAG:   state_d = last_flag ? FR_DATA : FR_FLAG;
				FR_DATA:   state_d = last_q ? FR_FCS_LO : FR_IDLE;
				FR_FCS_LO: state_d = FR_FCS_HI;
				FR_FCS_HI: state_d = FR_CLOSE;
				FR_CLOSE:  state_d = flush_q ? FR_TAIL : FR_IDLE;
				default:   state_d = FR_IDLE;
			endcase
		end
		if (accept) begin
			state_d = frame_start_in ? FR_FLAG : FR_DATA;
		end
	end

	// State and frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FR_IDLE;
			in_frame_q <= 1'b0;
			fcs_q      <= FCS_PRESET;
			flag_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				in_frame_q <= !byte_item.is_last;
				fcs_q      <= byte_item.is_last ? FCS_PRESET : crc_next;
				flag_cnt_q <= '0;
			end else if (push && (state_q == FR_FLAG)) begin
				flag_cnt_q <= flag_cnt_q + 1'b1;
			end
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q    <= byte_item.data_byte;
			last_q    <= byte_item.is_last;
			flush_q   <= byte_item.flush_tail;
			start_q   <= frame_start_in;
			fcs_out_q <= ~crc_next;
		end
	end

	a_no_accept_mid_byte: assert property (@(posedge clk) disable iff (!arst_n)
		push && !chunk.item_end |-> !byte_ready)
		else $error("byte accepted before the current byte was fully split");

endmodule

// File: rtl/core/hbsf_queue.sv
// ----------------------------------------------------------------------------
// hbsf_queue
// Small chunk queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module hbsf_queue
	import hbsf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  chunk_t wr_chunk,
	output logic   rd_valid,
	input  logic   rd_ready,
	output chunk_t rd_chunk
);

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

	chunk_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               wr_go;
	logic               rd_go;

	assign wr_ready = (count_q != COUNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_chunk = mem_q[rd_ptr_q];
	assign wr_go    = wr_valid && wr_ready;
	assign rd_go    = rd_valid && rd_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_go) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_go) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_go && !rd_go) begin
				count_q <= count_q + 1'b1;
			end else if (rd_go && !wr_go) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_ptr_q] <= wr_chunk;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("chunk queue fill level out of range");

endmodule

// File: rtl/core/hbsf_back.sv
// ----------------------------------------------------------------------------
// hbsf_back
// Stuffs chunk bits, packs them into words and marks run and frame ends.
// ----------------------------------------------------------------------------
module hbsf_back
	import hbsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       chunk_valid,
	output logic       chunk_ready,
	input  chunk_t     chunk,
	output logic       word_valid,
	input  logic       word_ready,
	output word_item_t word_item
);

	localparam int ACC_W = WORD_BITS + MAX_CHUNK_BITS - 1;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam int NB_W  = $clog2(WORD_BITS + 1);

	// Accumulator of line bits not yet packed out
	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   acc_cnt_q;
	logic [2:0]         ones_q;
	logic [TOTAL_W-1:0] total_q;

	// Ownership of the newest chunk taken
	logic               cur_tag_q;
	logic               cur_done_q;
	logic               done_end_q;
	logic [TOTAL_W-1:0] done_total_q;

	// Word held until it is known whether it ends its run
	logic                 p_valid_q;
	logic [WORD_BITS-1:0] p_word_q;
	logic [NB_W-1:0]      p_nbits_q;
	logic                 p_tag_q;

	// Output register
	logic       o_valid_q;
	word_item_t o_item_q;

	logic                 out_free;
	logic                 p_free;
	logic                 full_avail;
	logic                 p_final;
	logic                 emit_full;
	logic                 tail_emit;
	logic                 emit;
	logic                 p_release;
	logic                 is_tail;
	logic                 take;
	logic [CNT_W-1:0]     acc_after;
	logic [WORD_BITS-1:0] full_word;
	logic [WORD_BITS-1:0] tail_word;
	logic [WORD_BITS-1:0] emit_word;
	logic [NB_W-1:0]      emit_nbits;
	line_bits_t           lb;
	logic [TOTAL_W-1:0]   total_base;
	logic [TOTAL_W:0]     total_sum;
	logic [TOTAL_W-1:0]   total_new;

	// Serialize one byte, LSB first, with optional zero insertion
	function automatic line_bits_t line_bits(input logic [7:0] b,
			input logic [2:0] ones_in, input logic stuff_en);
		line_bits_t r;
		r.bits = '0;
		r.n    = '0;
		r.ones = ones_in;
		for (int i = 0; i < 8; i++) begin
			r.bits = {r.bits[MAX_CHUNK_BITS-2:0], b[i]};
			r.n    = r.n + 1'b1;
			if (stuff_en) begin
				if (b[i]) begin
					if (r.ones == STUFF_RUN - 3'd1) begin
						r.bits = {r.bits[MAX_CHUNK_BITS-2:0], 1'b0};
						r.n    = r.n + 1'b1;
						r.ones = '0;
					end else begin
						r.ones = r.ones + 1'b1;
					end
				end else begin
					r.ones = '0;
				end
			end
		end
		return r;
	endfunction

	// Decide what moves this cycle
	assign out_free   = !o_valid_q || word_ready;
	assign p_free     = !p_valid_q || out_free;
	assign full_avail = (acc_cnt_q >= CNT_W'(WORD_BITS));
	assign p_final    = p_valid_q &&
		((p_tag_q != cur_tag_q) || (cur_done_q && !full_avail));
	assign emit_full  = full_avail && p_free;
	assign acc_after  = emit_full ? (acc_cnt_q - CNT_W'(WORD_BITS)) : acc_cnt_q;
	assign is_tail    = (chunk.kind == CK_TAIL);

	assign chunk_ready = (acc_after < CNT_W'(WORD_BITS)) &&
		(!p_final || out_free) &&
		(!is_tail || (!full_avail && p_free));
	assign take        = chunk_valid && chunk_ready;
	assign tail_emit   = take && is_tail && (acc_cnt_q != '0);
	assign emit        = emit_full || tail_emit;
	assign p_release   = p_valid_q && out_free && (p_final || emit);

	// Extract a full word or the MSB-aligned tail
	assign full_word  = WORD_BITS'(acc_q >> (acc_cnt_q - CNT_W'(WORD_BITS)));
	assign tail_word  = WORD_BITS'(acc_q << (CNT_W'(WORD_BITS) - acc_cnt_q));
	assign emit_word  = tail_emit ? tail_word : full_word;
	assign emit_nbits = tail_emit ? NB_W'(acc_cnt_q) : NB_W'(WORD_BITS);

	// Serialize the incoming chunk and count its bits
	assign lb = line_bits(chunk.data, chunk.frame_start ? 3'd0 : ones_q,
		chunk.kind == CK_DATA);
	assign total_base = chunk.frame_start ? '0 : total_q;
	assign total_sum  = {1'b0, total_base} + (TOTAL_W + 1)'(lb.n);
	assign total_new  = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX :
		total_sum[TOTAL_W-1:0];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q  <= '0;
			ones_q     <= '0;
			total_q    <= '0;
			cur_tag_q  <= 1'b0;
			cur_done_q <= 1'b1;
			done_end_q <= 1'b0;
			p_valid_q  <= 1'b0;
			p_tag_q    <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			p_valid_q <= emit || (p_valid_q && !p_release);
			o_valid_q <= p_release || (o_valid_q && !word_ready);
			if (emit) begin
				p_tag_q <= cur_tag_q;
			end
			if (take) begin
				acc_cnt_q  <= is_tail ? '0 : (acc_after + CNT_W'(lb.n));
				cur_done_q <= chunk.item_end;
				if (chunk.first) begin
					cur_tag_q <= !cur_tag_q;
				end
				if (!is_tail) begin
					ones_q  <= lb.ones;
					total_q <= total_new;
				end
				if (chunk.item_end) begin
					done_end_q <= chunk.frame_last;
				end
			end else begin
				acc_cnt_q <= acc_after;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take && !is_tail) begin
			acc_q <= ACC_W'(acc_q << lb.n) | ACC_W'(lb.bits);
		end
		if (take && chunk.item_end) begin
			done_total_q <= is_tail ? total_q : total_new;
		end
		if (emit) begin
			p_word_q  <= emit_word;
			p_nbits_q <= emit_nbits;
		end
		if (p_release) begin
			o_item_q.out_word        <= p_word_q;
			o_item_q.valid_bits      <= p_nbits_q[3:0];
			o_item_q.frame_end       <= p_final && done_end_q;
			o_item_q.frame_bit_count <= (p_final && done_end_q) ? done_total_q : '0;
			o_item_q.last_of_run     <= p_final;
		end
	end

	assign word_valid = o_valid_q;
	assign word_item  = o_item_q;

	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && o_item_q.frame_end |-> o_item_q.last_of_run)
		else $error("frame end on a word that does not close its run");

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && !o_item_q.frame_end |-> o_item_q.frame_bit_count == '0)
		else $error("frame bit count on a word that does not end a frame");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt_q <= CNT_W'(ACC_W))
		else $error("bit accumulator overfilled");

endmodule

// File: rtl/core/hdlc_bit_stuffing_framer.sv
// ----------------------------------------------------------------------------
// hdlc_bit_stuffing_framer
// HDLC framer: flags, zero insertion, CRC-16 FCS and word packing.
// ----------------------------------------------------------------------------
// Input channel byte_*: one frame byte per request, LSB first on the line.
//   is_last closes the frame; flush_tail with it emits the partial tail word,
//   otherwise those bits lead the next frame. Opening flags precede the first
//   byte of each frame; FCS and closing flag follow the last.
// Output channel word_*: WORD_BITS-bit words, earliest bit in the MSB.
//   last_of_run marks the final word caused by one input byte; frame_end and
//   frame_bit_count mark the final word of a frame.
// Order: a completed word passes a hold register and the output register;
//   a word that may close its run waits in the hold register until that
//   byte's remaining bits are known.
// Throughput: mid-frame, one byte per cycle while nothing stalls and the back
//   packs one word per cycle; opening flags precede a frame's first byte, and
//   the two FCS bytes, closing flag and a flushed tail follow the closing byte.
//   The packer's one word per cycle sets the sustained rate.
// Reset: queues empty, outside any frame, FCS preset to all ones.
// When the receiver stalls the output register holds, then the packer and
//   the chunk queue fill, and byte_ready drops.
// ----------------------------------------------------------------------------
module hdlc_bit_stuffing_framer
	import hbsf_pkg::*;
#(
	parameter int START_FLAGS = DEF_START_FLAGS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  byte_item_t byte_item,
	output logic       word_valid,
	input  logic       word_ready,
	output word_item_t word_item
);

	logic   fq_valid;
	logic   fq_ready;
	chunk_t fq_chunk;
	logic   qb_valid;
	logic   qb_ready;
	chunk_t qb_chunk;

	// Split bytes into chunks and run the FCS
	hbsf_front #(
		.START_FLAGS(START_FLAGS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.chunk_valid(fq_valid),
		.chunk_ready(fq_ready),
		.chunk      (fq_chunk)
	);

	// Decouple front and back
	hbsf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_chunk(fq_chunk),
		.rd_valid(qb_valid),
		.rd_ready(qb_ready),
		.rd_chunk(qb_chunk)
	);

	// Stuff, pack and mark words
	hbsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.chunk_valid(qb_valid),
		.chunk_ready(qb_ready),
		.chunk      (qb_chunk),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_item  (word_item)
	);

endmodule
